[rtl/irti_pkg.sv]
// Shared types and constants for the image rotation / triangle interpolation block.
package irti_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TRIG_BITS      = 14;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0] PIX_WHITE = 8'd255;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       inside_res;
        logic [7:0] out_x;
        logic [7:0] out_y;
    } out_t;

    // Query bookkeeping that travels with the frame store read
    typedef struct packed {
        logic       query;
        logic       in_bounds;
        logic       ix0;
        logic       iy0;
        logic [7:0] x;
        logic [7:0] y;
    } qmeta_t;

endpackage

[rtl/image_rotate_triangle_interp_top.sv]
// Top level of the gray image rotator with triangle interpolation.
//
// One beat per clock in, one result per query beat out. Five register stages
// (products, mapped point, store read, weights, output) carry each accepted
// input beat to the output register. Loads and queries share one pipeline
// and touch the frame store at the same stage, so a query sees every load
// ahead of it. The store is split into four banks by pixel parity, giving
// all four corner reads of a cell at once. The whole pipeline stalls only
// while a result sits in the output register and is not taken.
module image_rotate_triangle_interp_top #(
    parameter int MAX_WIDTH  = irti_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irti_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = irti_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  irti_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output irti_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irti_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int QW = 27 + FRAC_BITS;

    logic                 en;
    logic signed [15:0]   cos_reg, sin_reg;
    logic signed [19:0]   offx_reg, offy_reg;
    logic [8:0]           width_reg, height_reg;
    logic                 st2_valid;
    irti_pkg::in_t        st2_data;
    logic signed [QW-1:0] qx, qy;
    irti_pkg::qmeta_t     st3_meta;
    logic [FRAC_BITS-1:0] st3_fx, st3_fy;
    logic [7:0]           corner_pix [4];

    // Global advance: move whenever the output slot is free or draining
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= 16'sd16384;
            sin_reg    <= '0;
            offx_reg   <= '0;
            offy_reg   <= '0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                irti_pkg::CFG_COS:    cos_reg    <= cfg_data[15:0];
                irti_pkg::CFG_SIN:    sin_reg    <= cfg_data[15:0];
                irti_pkg::CFG_OFF_X:  offx_reg   <= cfg_data;
                irti_pkg::CFG_OFF_Y:  offy_reg   <= cfg_data;
                irti_pkg::CFG_WIDTH:  width_reg  <= cfg_data[8:0];
                irti_pkg::CFG_HEIGHT: height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    irti_map #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cos_q14   (cos_reg),
        .sin_q14   (sin_reg),
        .offset_x  (offx_reg),
        .offset_y  (offy_reg),
        .st2_valid (st2_valid),
        .st2_data  (st2_data),
        .qx        (qx),
        .qy        (qy)
    );

    irti_fetch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .QW         (QW)
    ) u_fetch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .st2_valid    (st2_valid),
        .st2_data     (st2_data),
        .qx           (qx),
        .qy           (qy),
        .image_width  (width_reg),
        .image_height (height_reg),
        .st3_meta     (st3_meta),
        .st3_fx       (st3_fx),
        .st3_fy       (st3_fy),
        .corner_pix   (corner_pix)
    );

    irti_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .st3_meta   (st3_meta),
        .st3_fx     (st3_fx),
        .st3_fy     (st3_fy),
        .corner_pix (corner_pix),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

    // Outside results are always white
    a_outside_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.inside_res |-> m_data.pixel_out == irti_pkg::PIX_WHITE)
        else $error("outside result not white");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A held result blocks intake
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // A held result stays put until taken
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");
endmodule

[rtl/irti_ram.sv]
// Generic simple dual-port RAM with registered read.
module irti_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);
    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/irti_map.sv]
// Forward coordinate mapping: product stage, then sum/floor stage.
module irti_map #(
    parameter int FRAC_BITS = irti_pkg::FRAC_BITS_DEF,
    parameter int QW        = 27 + FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  irti_pkg::in_t          in_data,
    input  logic signed [15:0]     cos_q14,
    input  logic signed [15:0]     sin_q14,
    input  logic signed [19:0]     offset_x,
    input  logic signed [19:0]     offset_y,
    output logic                   st2_valid,
    output irti_pkg::in_t          st2_data,
    output logic signed [QW-1:0]   qx,
    output logic signed [QW-1:0]   qy
);
    localparam int AFW = 26 + FRAC_BITS;

    logic                 v1_reg, v2_reg;
    irti_pkg::in_t        d1_reg, d2_reg;
    logic signed [24:0]   p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic signed [24:0]   p_cx_next, p_sy_next, p_sx_next, p_cy_next;
    logic signed [QW-1:0] qx_reg, qy_reg, qx_next, qy_next;
    logic signed [25:0]   ax, ay;
    logic signed [AFW-1:0] afx, afy, shx, shy;
    logic signed [8:0]    sx, sy;

    // Stage 1: four rotation products
    always_comb begin
        sx = $signed({1'b0, in_data.pos_x});
        sy = $signed({1'b0, in_data.pos_y});
        p_cx_next = cos_q14 * sx;
        p_sy_next = sin_q14 * sy;
        p_sx_next = sin_q14 * sx;
        p_cy_next = cos_q14 * sy;
    end

    // Stage 2: combine, scale to coordinate fraction, floor, add offset
    always_comb begin
        ax  = 26'(p_cx_reg) - 26'(p_sy_reg);
        ay  = 26'(p_sx_reg) + 26'(p_cy_reg);
        afx = {ax, {FRAC_BITS{1'b0}}};
        afy = {ay, {FRAC_BITS{1'b0}}};
        shx = afx >>> irti_pkg::TRIG_BITS;
        shy = afy >>> irti_pkg::TRIG_BITS;
        qx_next = QW'(shx) + QW'(offset_x);
        qy_next = QW'(shy) + QW'(offset_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg   <= in_data;
            p_cx_reg <= p_cx_next;
            p_sy_reg <= p_sy_next;
            p_sx_reg <= p_sx_next;
            p_cy_reg <= p_cy_next;
            d2_reg   <= d1_reg;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
        end
    end

    assign st2_valid = v2_reg;
    assign st2_data  = d2_reg;
    assign qx        = qx_reg;
    assign qy        = qy_reg;
endmodule

[rtl/irti_fetch.sv]
// Bounds test and four-bank frame store access (loads and corner reads).
module irti_fetch #(
    parameter int MAX_WIDTH  = irti_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irti_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = irti_pkg::FRAC_BITS_DEF,
    parameter int QW         = 27 + FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  st2_valid,
    input  irti_pkg::in_t         st2_data,
    input  logic signed [QW-1:0]  qx,
    input  logic signed [QW-1:0]  qy,
    input  logic [8:0]            image_width,
    input  logic [8:0]            image_height,
    output irti_pkg::qmeta_t      st3_meta,
    output logic [FRAC_BITS-1:0]  st3_fx,
    output logic [FRAC_BITS-1:0]  st3_fy,
    output logic [7:0]            corner_pix [4]
);
    localparam int XW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HXW = (MAX_WIDTH  > 2) ? $clog2((MAX_WIDTH  + 1) / 2) : 1;
    localparam int HYW = (MAX_HEIGHT > 2) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
    localparam int WWX = ($clog2(MAX_WIDTH  + 1) > 9) ? $clog2(MAX_WIDTH  + 1) : 9;
    localparam int WWY = ($clog2(MAX_HEIGHT + 1) > 9) ? $clog2(MAX_HEIGHT + 1) : 9;
    localparam int BAW = HXW + HYW;
    localparam int BDEPTH = 2 ** BAW;

    logic [WWX-1:0] w_clamp, lim_x;
    logic [WWY-1:0] h_clamp, lim_y;
    logic           in_x, in_y, in_bounds;
    logic [XW-1:0]  ix, lx;
    logic [YW-1:0]  iy, ly;
    logic           load_ok;
    logic [BAW-1:0] raddr [4];
    logic [BAW-1:0] waddr;
    logic [XW:0]    cx [4];
    logic [YW:0]    cy [4];
    logic [XW-1:0]  cxh [4];
    logic [YW-1:0]  cyh [4];
    logic [XW-1:0]  lxh;
    logic [YW-1:0]  lyh;
    logic [3:0]     bank_we;

    irti_pkg::qmeta_t     meta_reg, meta_next;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;

    // Clamped source size and bounds test on the mapped point
    always_comb begin
        if (WWX'(image_width) < WWX'(2)) begin
            w_clamp = WWX'(2);
        end else if (WWX'(image_width) > WWX'(MAX_WIDTH)) begin
            w_clamp = WWX'(MAX_WIDTH);
        end else begin
            w_clamp = WWX'(image_width);
        end
        if (WWY'(image_height) < WWY'(2)) begin
            h_clamp = WWY'(2);
        end else if (WWY'(image_height) > WWY'(MAX_HEIGHT)) begin
            h_clamp = WWY'(MAX_HEIGHT);
        end else begin
            h_clamp = WWY'(image_height);
        end
        lim_x     = w_clamp - WWX'(2);
        lim_y     = h_clamp - WWY'(2);
        in_x      = !qx[QW-1] && (qx[QW-2:0] <= (QW-1)'({lim_x, {FRAC_BITS{1'b0}}}));
        in_y      = !qy[QW-1] && (qy[QW-2:0] <= (QW-1)'({lim_y, {FRAC_BITS{1'b0}}}));
        in_bounds = in_x && in_y;
        ix        = qx[FRAC_BITS+XW-1:FRAC_BITS];
        iy        = qy[FRAC_BITS+YW-1:FRAC_BITS];
    end

    // Bank b = {y[0], x[0]}; each cell corner lands in a distinct bank
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            cx[b]    = (XW+1)'(ix) + (XW+1)'(b[0] ^ ix[0]);
            cy[b]    = (YW+1)'(iy) + (YW+1)'(b[1] ^ iy[0]);
            cxh[b]   = cx[b][XW:1];
            cyh[b]   = cy[b][YW:1];
            raddr[b] = {cyh[b][HYW-1:0], cxh[b][HXW-1:0]};
        end
    end

    // Load write address
    always_comb begin
        lx      = XW'(st2_data.pos_x);
        ly      = YW'(st2_data.pos_y);
        lxh     = lx >> 1;
        lyh     = ly >> 1;
        waddr   = {lyh[HYW-1:0], lxh[HXW-1:0]};
        load_ok = st2_valid && (st2_data.opcode == irti_pkg::OP_LOAD)
                  && (32'(st2_data.pos_x) < MAX_WIDTH)
                  && (32'(st2_data.pos_y) < MAX_HEIGHT);
        for (int b = 0; b < 4; b++) begin
            bank_we[b] = en && load_ok && ({ly[0], lx[0]} == 2'(b));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        irti_ram #(
            .DW    (8),
            .DEPTH (BDEPTH)
        ) u_bank (
            .aclk  (aclk),
            .we    (bank_we[g]),
            .waddr (waddr),
            .wdata (st2_data.pixel_in),
            .re    (en),
            .raddr (raddr[g]),
            .rdata (corner_pix[g])
        );
    end

    always_comb begin
        meta_next.query     = st2_valid && (st2_data.opcode == irti_pkg::OP_QUERY);
        meta_next.in_bounds = in_bounds;
        meta_next.ix0       = ix[0];
        meta_next.iy0       = iy[0];
        meta_next.x         = st2_data.pos_x;
        meta_next.y         = st2_data.pos_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg.query <= 1'b0;
        end else if (en) begin
            meta_reg.query <= meta_next.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg.in_bounds <= meta_next.in_bounds;
            meta_reg.ix0       <= meta_next.ix0;
            meta_reg.iy0       <= meta_next.iy0;
            meta_reg.x         <= meta_next.x;
            meta_reg.y         <= meta_next.y;
            fx_reg             <= qx[FRAC_BITS-1:0];
            fy_reg             <= qy[FRAC_BITS-1:0];
        end
    end

    assign st3_meta = meta_reg;
    assign st3_fx   = fx_reg;
    assign st3_fy   = fy_reg;
endmodule

[rtl/irti_interp.sv]
// Triangle selection, weight products, and final sum into the output register.
module irti_interp #(
    parameter int FRAC_BITS = irti_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  irti_pkg::qmeta_t      st3_meta,
    input  logic [FRAC_BITS-1:0]  st3_fx,
    input  logic [FRAC_BITS-1:0]  st3_fy,
    input  logic [7:0]            corner_pix [4],
    output logic                  m_valid,
    output irti_pkg::out_t        m_data
);
    localparam int PW = FRAC_BITS + 10;
    localparam int ZW = FRAC_BITS + 11;

    logic [7:0]        z1, zr, zd, z3, z2;
    logic              upper;
    logic signed [8:0] da, db, ma, mb;
    logic signed [PW-1:0] pa_next, pb_next, pa_reg, pb_reg;
    logic [7:0]        z1_reg;
    irti_pkg::qmeta_t  m4_reg;
    logic signed [ZW-1:0] zq;
    logic [ZW-1:0]     zsh;
    logic [7:0]        res;
    logic              v5_reg;
    irti_pkg::out_t    out_reg, out_next;

    // Stage 4: pick the triangle and form both weighted differences
    always_comb begin
        z1    = corner_pix[{st3_meta.iy0, st3_meta.ix0}];
        zr    = corner_pix[{st3_meta.iy0, ~st3_meta.ix0}];
        zd    = corner_pix[{~st3_meta.iy0, st3_meta.ix0}];
        z3    = corner_pix[{~st3_meta.iy0, ~st3_meta.ix0}];
        upper = st3_fy < st3_fx;
        z2    = upper ? zr : zd;
        da    = $signed({1'b0, z1}) - $signed({1'b0, z2});
        db    = $signed({1'b0, z2}) - $signed({1'b0, z3});
        ma    = upper ? da : db;
        mb    = upper ? db : da;
        pa_next = ma * $signed({1'b0, st3_fx});
        pb_next = mb * $signed({1'b0, st3_fy});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_reg.query <= 1'b0;
        end else if (en) begin
            m4_reg.query <= st3_meta.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_reg.in_bounds <= st3_meta.in_bounds;
            m4_reg.ix0       <= st3_meta.ix0;
            m4_reg.iy0       <= st3_meta.iy0;
            m4_reg.x         <= st3_meta.x;
            m4_reg.y         <= st3_meta.y;
            z1_reg           <= z1;
            pa_reg           <= pa_next;
            pb_reg           <= pb_next;
        end
    end

    // Stage 5: sum, clamp, truncate
    always_comb begin
        zq  = $signed(ZW'({z1_reg, {FRAC_BITS{1'b0}}})) - ZW'(pa_reg) - ZW'(pb_reg);
        zsh = zq[ZW-1] ? '0 : (ZW'(zq) >> FRAC_BITS);
        res = (zsh > ZW'(255)) ? irti_pkg::PIX_WHITE : zsh[7:0];
        out_next.pixel_out  = m4_reg.in_bounds ? res : irti_pkg::PIX_WHITE;
        out_next.inside_res = m4_reg.in_bounds;
        out_next.out_x      = m4_reg.x;
        out_next.out_y      = m4_reg.y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= m4_reg.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = v5_reg;
    assign m_data  = out_reg;
endmodule

[tb/irti_checker.sv]
// Scoreboard for the rotator: watches all three channels, predicts each query result and compares.
`timescale 1ns / 1ps

module irti_checker
    import irti_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    results_seen
);

    // Shadow copy of the source frame and the rotation registers
    logic [7:0]  frame_mem [0:65535];
    logic signed [15:0] rot_cos, rot_sin;
    logic signed [19:0] shift_x, shift_y;
    logic [8:0]  src_w, src_h;

    out_t pixel_q [$];

    function automatic int clamp_size(input logic [8:0] v);
        if (v < 2) return 2;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    // Forward-map one axis; returns 0 when the point leaves [0, lim]
    function automatic bit map_axis(input longint a, input longint off, input int lim,
                                    output longint q);
        longint full;
        full = a * 256 + off * 16384;
        q = 0;
        if (full < 0) return 0;
        q = full >>> TRIG_BITS;
        return q <= (longint'(lim) << FRAC_BITS_DEF);
    endfunction

    function automatic out_t rotate_pixel(input in_t d);
        out_t   r;
        longint qx, qy, fx, fy, z1, z2, z3, zq;
        int     ix, iy;
        bit     ins;
        r.out_x = d.pos_x;
        r.out_y = d.pos_y;
        r.pixel_out = PIX_WHITE;
        ins = map_axis(longint'(rot_cos) * d.pos_x - longint'(rot_sin) * d.pos_y,
                       longint'(shift_x), clamp_size(src_w) - 2, qx);
        if (ins)
            ins = map_axis(longint'(rot_sin) * d.pos_x + longint'(rot_cos) * d.pos_y,
                           longint'(shift_y), clamp_size(src_h) - 2, qy);
        r.inside_res = ins;
        if (ins) begin
            ix = int'(qx >> 8);
            iy = int'(qy >> 8);
            fx = qx & 255;
            fy = qy & 255;
            z1 = frame_mem[iy * 256 + ix];
            z3 = frame_mem[(iy + 1) * 256 + ix + 1];
            // upper-right triangle when frac_y < frac_x, else lower-left
            if (fy < fx) begin
                z2 = frame_mem[iy * 256 + ix + 1];
                zq = z1 * 256 - (z1 - z2) * fx - (z2 - z3) * fy;
            end else begin
                z2 = frame_mem[(iy + 1) * 256 + ix];
                zq = z1 * 256 - (z2 - z3) * fx - (z1 - z2) * fy;
            end
            if (zq < 0) zq = 0;
            zq = zq >>> 8;
            if (zq > 255) zq = 255;
            r.pixel_out = zq[7:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            rot_cos <= 16'sd16384;
            rot_sin <= '0;
            shift_x <= '0;
            shift_y <= '0;
            src_w   <= 9'd256;
            src_h   <= 9'd256;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COS:    rot_cos <= cfg_data[15:0];
                    CFG_SIN:    rot_sin <= cfg_data[15:0];
                    CFG_OFF_X:  shift_x <= cfg_data;
                    CFG_OFF_Y:  shift_y <= cfg_data;
                    CFG_WIDTH:  src_w   <= cfg_data[8:0];
                    CFG_HEIGHT: src_h   <= cfg_data[8:0];
                    default: ;
                endcase
            end
            // input beats: loads update the frame, queries queue a prediction
            if (s_valid && s_ready) begin
                if (s_data.opcode == OP_LOAD)
                    frame_mem[{s_data.pos_y, s_data.pos_x}] = s_data.pixel_in;
                else
                    pixel_q.push_back(rotate_pixel(s_data));
            end
            // result beats
            if (m_valid && m_ready) begin
                results_seen++;
                if (pixel_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", m_data);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_data.pixel_out !== want.pixel_out) begin
                        $error("pixel_out exp %0d got %0d", want.pixel_out, m_data.pixel_out);
                        errors++;
                    end
                    if (m_data.inside_res !== want.inside_res) begin
                        $error("inside_res exp %0d got %0d", want.inside_res,
                               m_data.inside_res);
                        errors++;
                    end
                    if (m_data.out_x !== want.out_x) begin
                        $error("out_x exp %0d got %0d", want.out_x, m_data.out_x);
                        errors++;
                    end
                    if (m_data.out_y !== want.out_y) begin
                        $error("out_y exp %0d got %0d", want.out_y, m_data.out_y);
                        errors++;
                    end
                end
            end
        end
        pending = pixel_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, stimulus for loads, queries and register writes, and the verdict.
`timescale 1ns / 1ps

module tb;
    import irti_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RAND_ITEMS  = 1750;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors, pending, results_seen;
    int beats = 0, queries = 0, settings = 0;
    int stall_cnt = 0;
    logic calm = 1'b0;

    // stimulus-side view of the registers, used to keep queries on written pixels
    int  t_cos = 16384, t_sin = 0, t_offx = 0, t_offy = 0, t_w = 256, t_h = 256;
    bit  written [0:65535];

    image_rotate_triangle_interp_top uut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    irti_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending, .results_seen
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(99) >= 13);
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else if (aresetn) begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        if (calm || $urandom_range(99) >= 13) return 0;
        return $urandom_range(1, 4);
    endfunction

    task automatic push_beat(input in_t d);
        int   g;
        logic rdy;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        beats++;
    endtask

    task automatic load_pixel(input int x, input int y, input int v);
        in_t d;
        d.opcode   = OP_LOAD;
        d.pos_x    = x[7:0];
        d.pos_y    = y[7:0];
        d.pixel_in = v[7:0];
        written[{d.pos_y, d.pos_x}] = 1'b1;
        push_beat(d);
    endtask

    function automatic int clamp_dim(input int v);
        return v < 2 ? 2 : (v > 256 ? 256 : v);
    endfunction

    // which source cell a destination pixel lands in; 0 when it falls outside
    function automatic bit find_cell(input int x, input int y, output int ix, output int iy);
        longint fx, fy;
        fx = (longint'(t_cos) * x - longint'(t_sin) * y) * 256 + longint'(t_offx) * 16384;
        fy = (longint'(t_sin) * x + longint'(t_cos) * y) * 256 + longint'(t_offy) * 16384;
        ix = 0;
        iy = 0;
        if (fx < 0 || fy < 0) return 0;
        fx = fx >>> 14;
        fy = fy >>> 14;
        if (fx > longint'(clamp_dim(t_w) - 2) * 256) return 0;
        if (fy > longint'(clamp_dim(t_h) - 2) * 256) return 0;
        ix = int'(fx >> 8);
        iy = int'(fy >> 8);
        return 1;
    endfunction

    // query, first loading any corner of the hit cell not yet written
    task automatic query_pixel(input int x, input int y);
        in_t d;
        int  ix, iy;
        if (find_cell(x, y, ix, iy)) begin
            for (int k = 0; k < 4; k++)
                if (!written[(iy + k / 2) * 256 + ix + k % 2])
                    load_pixel(ix + k % 2, iy + k / 2, $urandom_range(255));
        end
        d.opcode   = OP_QUERY;
        d.pos_x    = x[7:0];
        d.pos_y    = y[7:0];
        d.pixel_in = $urandom_range(255);
        queries++;
        push_beat(d);
    endtask

    // hold the sender until every result is back and the pipe has emptied
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int v);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_DATA_W-1:0];
        do begin
            @(negedge aclk);
            rdy = cfg_ready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    // write all six registers; unused upper data bits carry noise
    task automatic set_rotation(input int c, input int s, input int ox, input int oy,
                                input int w, input int h);
        drain();
        cfg_put(CFG_COS,    int'({4'($urandom_range(15)), c[15:0]}));
        cfg_put(CFG_SIN,    int'({4'($urandom_range(15)), s[15:0]}));
        cfg_put(CFG_OFF_X,  ox);
        cfg_put(CFG_OFF_Y,  oy);
        cfg_put(CFG_WIDTH,  int'({11'($urandom_range(2047)), w[8:0]}));
        cfg_put(CFG_HEIGHT, int'({11'($urandom_range(2047)), h[8:0]}));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        t_cos  = $signed(c[15:0]);
        t_sin  = $signed(s[15:0]);
        t_offx = $signed(ox[19:0]);
        t_offy = $signed(oy[19:0]);
        t_w    = w[8:0];
        t_h    = h[8:0];
        settings++;
    endtask

    initial begin
        int w, h, span, c, s, ox, oy;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity mapping at reset values: corners and edge of bounds
        load_pixel(0, 0, 0);
        load_pixel(255, 255, 255);
        query_pixel(0, 0);
        query_pixel(254, 254);
        query_pixel(255, 0);
        query_pixel(255, 255);
        query_pixel(128, 77);

        // half-pixel offsets: both triangles and the diagonal itself
        set_rotation(16384, 0, 128, 64, 256, 256);
        query_pixel(10, 10);
        query_pixel(253, 253);
        set_rotation(16384, 0, 64, 192, 16, 16);
        query_pixel(3, 4);
        set_rotation(16384, 0, 96, 96, 16, 16);
        query_pixel(5, 5);
        // negative offset pushes the point below zero
        set_rotation(16384, 0, -1, 0, 16, 16);
        query_pixel(0, 0);
        // size clamps: below two and above the store
        set_rotation(16384, 0, 0, 0, 0, 1);
        query_pixel(0, 0);
        query_pixel(1, 0);
        set_rotation(16384, 0, 0, 0, 511, 300);
        query_pixel(254, 254);
        query_pixel(255, 200);
        // quarter and half turns, and register extremes
        set_rotation(0, 16384, 100 * 256, 0, 256, 256);
        query_pixel(40, 20);
        set_rotation(-16384, -16384, 524287, -524288, 256, 256);
        query_pixel(255, 255);
        query_pixel(0, 0);
        set_rotation(-16384, 0, 200 * 256 + 37, 200 * 256 + 211, 256, 256);
        query_pixel(7, 180);

        // random phases: mostly queries landing in the image, some stray loads
        while (beats < RAND_ITEMS - 100) begin
            case ($urandom_range(9))
                0:       begin w = $urandom_range(511); h = $urandom_range(511); end
                1:       begin w = 256; h = 256; end
                default: begin w = $urandom_range(2, 40); h = $urandom_range(2, 40); end
            endcase
            span = clamp_dim(w) > clamp_dim(h) ? clamp_dim(w) : clamp_dim(h);
            c = $urandom_range(32768) - 16384;
            s = $urandom_range(32768) - 16384;
            if ($urandom_range(4) == 0) begin
                ox = $urandom_range(1048575) - 524288;
                oy = $urandom_range(1048575) - 524288;
            end else begin
                ox = $urandom_range(clamp_dim(w) * 512) - clamp_dim(w) * 128;
                oy = $urandom_range(clamp_dim(h) * 512) - clamp_dim(h) * 128;
                ox = ox - (c - s) * span / 128;
                oy = oy - (c + s) * span / 128;
                if (ox > 524287) ox = 524287;
                if (ox < -524288) ox = -524288;
                if (oy > 524287) oy = 524287;
                if (oy < -524288) oy = -524288;
            end
            set_rotation(c, s, ox, oy, w, h);
            calm = (settings % 7 == 3);
            repeat ($urandom_range(60, 200)) begin
                if ($urandom_range(99) < 20)
                    load_pixel($urandom_range(span - 1), $urandom_range(span - 1),
                               $urandom_range(255));
                else if ($urandom_range(99) < 10)
                    query_pixel($urandom_range(255), $urandom_range(255));
                else
                    query_pixel($urandom_range(span - 1), $urandom_range(span - 1));
                if ($urandom_range(299) == 0)
                    drain();
            end
            calm = 1'b0;
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("Covered %0d input beats (%0d queries, %0d results) over %0d register settings,",
                 beats, queries, results_seen, settings);
        $display("including clamped sizes, extreme offsets and both interpolation triangles.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[image_rotate_triangle_interp_top.f]
rtl/irti_pkg.sv
rtl/irti_ram.sv
rtl/irti_map.sv
rtl/irti_fetch.sv
rtl/irti_interp.sv
rtl/image_rotate_triangle_interp_top.sv
tb/irti_checker.sv
tb/tb.sv
